@@ rtl/ttdr_pkg.sv @@
// Package for the touch tag debounce and auto-repeat block: types, codes and helpers.
`timescale 1ns / 1ps
`default_nettype none
package ttdr_pkg;

  localparam int TIMER_BITS = 16;
  localparam int CFG_AW     = 4;

  localparam logic [7:0] NO_TAG = 8'h00;

  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_START = 2'd1;
  localparam logic [1:0] EV_HELD  = 2'd2;
  localparam logic [1:0] EV_END   = 2'd3;

  localparam logic [1:0] SND_NONE    = 2'd0;
  localparam logic [1:0] SND_PRESS   = 2'd1;
  localparam logic [1:0] SND_REPEAT  = 2'd2;
  localparam logic [1:0] SND_UNPRESS = 2'd3;

  localparam logic OP_TICK   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // byte addresses of the configuration registers
  localparam logic [CFG_AW-1:0] ADDR_UPDATE_INTERVAL = 4'h0;
  localparam logic [CFG_AW-1:0] ADDR_REPEAT_PERIOD   = 4'h4;
  localparam logic [CFG_AW-1:0] ADDR_DEBOUNCE_PERIOD = 4'h8;
  localparam logic [CFG_AW-1:0] ADDR_SOUNDS_ENABLED  = 4'hC;

  typedef struct packed {
    logic       op;
    logic [7:0] tag;
    logic       display_busy;
    logic       start_accepted;
    logic       hold_accepted;
    logic       start_changes_screen;
  } in_item_t;

  typedef struct packed {
    logic [1:0] event_kind;
    logic [7:0] event_tag;
    logic [1:0] sound_request;
    logic       refresh_request;
    logic [7:0] held_tag;
  } out_item_t;

  // Interval is done once reached, or once the timer has saturated.
  function automatic logic timer_done(input logic [TIMER_BITS-1:0] elapsed,
                                      input logic [15:0] interval);
    logic [32:0] e_ext;
    logic [32:0] i_ext;
    e_ext = 33'(elapsed);
    i_ext = 33'(interval);
    return (e_ext >= i_ext) || (elapsed == {TIMER_BITS{1'b1}});
  endfunction

endpackage
`default_nettype wire

@@ rtl/touch_tag_debounce_repeat.sv @@
// Touch tag qualifier: touch start, auto-repeat held and debounced touch end events.
//
//   channel | direction | handshake          | payload
//   in_     | input     | in_valid/in_stall  | in_data  (in_item_t)
//   out_    | output    | out_valid/out_stall| out_data (out_item_t)
//   cfg     | input     | APB psel/penable   | paddr/pwdata/prdata
//
// One beat per cycle while the result is not stalled: a beat sits in the input
// register, is evaluated against the press state and timer, and lands in the
// result register.
// Synchronous active-low reset clears the press state and saturates the timer.
// A stalled result holds the input register; the input register still takes
// a beat while it is empty, so one beat waits behind a stalled result.
`timescale 1ns / 1ps
`default_nettype none
module touch_tag_debounce_repeat
  import ttdr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_item_t              out_data,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  logic [15:0] update_interval_r;
  logic [15:0] repeat_period_r;
  logic [15:0] debounce_period_r;
  logic        sounds_enabled_r;

  logic [7:0]            pressed_id_r, pressed_id_nxt;
  logic                  debouncing_r, debouncing_nxt;
  logic                  skip_release_r, skip_release_nxt;
  logic [TIMER_BITS-1:0] elapsed_r, elapsed_nxt;

  in_item_t  in_r;
  logic      in_valid_r;
  out_item_t out_r, out_nxt;
  logic      out_valid_r;
  logic      advance;
  logic      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr)
      ADDR_UPDATE_INTERVAL: prdata = {16'd0, update_interval_r};
      ADDR_REPEAT_PERIOD:   prdata = {16'd0, repeat_period_r};
      ADDR_DEBOUNCE_PERIOD: prdata = {16'd0, debounce_period_r};
      ADDR_SOUNDS_ENABLED:  prdata = {31'd0, sounds_enabled_r};
      default:              prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      update_interval_r <= 16'd20;
      repeat_period_r   <= 16'd250;
      debounce_period_r <= 16'd100;
      sounds_enabled_r  <= 1'b1;
    end else if (cfg_wr) begin
      unique case (paddr)
        ADDR_UPDATE_INTERVAL: update_interval_r <= pwdata[15:0];
        ADDR_REPEAT_PERIOD:   repeat_period_r   <= pwdata[15:0];
        ADDR_DEBOUNCE_PERIOD: debounce_period_r <= pwdata[15:0];
        ADDR_SOUNDS_ENABLED:  sounds_enabled_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // evaluate the held beat whenever the result register can take it
  assign advance  = in_valid_r && !(out_valid_r && out_stall);
  assign in_stall = in_valid_r && !advance;

  always_comb begin
    pressed_id_nxt   = pressed_id_r;
    debouncing_nxt   = debouncing_r;
    skip_release_nxt = skip_release_r;
    elapsed_nxt      = elapsed_r;
    out_nxt          = '0;

    if (in_r.op == OP_TICK) begin
      if (elapsed_r != {TIMER_BITS{1'b1}}) begin
        elapsed_nxt = elapsed_r + TIMER_BITS'(1);
      end
    end else if (!in_r.display_busy && timer_done(elapsed_r, update_interval_r)) begin
      if (pressed_id_r == NO_TAG) begin
        if (in_r.tag != NO_TAG) begin
          pressed_id_nxt          = in_r.tag;
          out_nxt.refresh_request = 1'b1;
          out_nxt.event_kind      = EV_START;
          out_nxt.event_tag       = in_r.tag;
          if (in_r.start_accepted) begin
            elapsed_nxt = '0;
            if (sounds_enabled_r) out_nxt.sound_request = SND_PRESS;
          end
          skip_release_nxt = in_r.start_changes_screen;
        end else begin
          elapsed_nxt = '0;
        end
      end else if (!debouncing_r) begin
        if (in_r.tag == pressed_id_r) begin
          if (timer_done(elapsed_r, repeat_period_r)) begin
            out_nxt.event_kind = EV_HELD;
            out_nxt.event_tag  = in_r.tag;
            if (in_r.hold_accepted) begin
              if (sounds_enabled_r) out_nxt.sound_request = SND_REPEAT;
              elapsed_nxt = '0;
            end
          end
        end else if (in_r.tag == NO_TAG) begin
          elapsed_nxt    = '0;
          debouncing_nxt = 1'b1;
        end
      end else begin
        if (in_r.tag == pressed_id_r) begin
          debouncing_nxt = 1'b0;
        end else if (timer_done(elapsed_r, debounce_period_r)) begin
          debouncing_nxt = 1'b0;
          pressed_id_nxt = NO_TAG;
          if (skip_release_r) begin
            // end after a screen change is swallowed
            skip_release_nxt = 1'b0;
          end else begin
            if (sounds_enabled_r) out_nxt.sound_request = SND_UNPRESS;
            out_nxt.event_kind      = EV_END;
            out_nxt.event_tag       = pressed_id_r;
            out_nxt.refresh_request = 1'b1;
          end
        end
      end
    end
    out_nxt.held_tag = pressed_id_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pressed_id_r   <= NO_TAG;
      debouncing_r   <= 1'b0;
      skip_release_r <= 1'b0;
      elapsed_r      <= {TIMER_BITS{1'b1}};
      in_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (advance) begin
        pressed_id_r   <= pressed_id_nxt;
        debouncing_r   <= debouncing_nxt;
        skip_release_r <= skip_release_nxt;
        elapsed_r      <= elapsed_nxt;
        out_valid_r    <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_r <= in_data;
    end
    if (advance) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire
